### hdl/fifo_cache_miss_counter_defines.svh
// Assertion macros shared by the FIFO cache miss counter RTL.
`ifndef FIFO_CACHE_MISS_COUNTER_DEFINES_SVH
`define FIFO_CACHE_MISS_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define FCMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cons must hold in the cycle after ante
`define FCMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FCMC_ASSERT(label, prop, msg)
`define FCMC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### hdl/fcmc_pkg.sv
// Shared constants, types and helper functions of the FIFO cache miss counter.
package fcmc_pkg;

  localparam int NUM_CACHES     = 4;
  localparam int MAX_ENTRIES    = 64;
  localparam int NUM_CAP_REGS   = 4;
  localparam int NUM_OUT        = 4;
  localparam int DEFAULT_CAP    = 16;
  localparam int DEFAULT_ACTIVE = 4;

  localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int FILL_W     = $clog2(MAX_ENTRIES + 1);
  localparam int ACT_W      = $clog2(NUM_CACHES + 1);
  localparam int CAP_W      = 7;
  localparam int ACTREG_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 16;
  localparam int MISS_W     = 32;
  localparam int OP_W       = 2;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd0;
  localparam int                   REG_CAP0   = 1;

  typedef enum logic [OP_W-1:0] {
    OP_ACCESS = 2'd0,
    OP_RANGE  = 2'd1,
    OP_STAT   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;        // capture input item
    logic scan_start;  // reset scan index and hit flags
    logic scan;        // issue next entry read
    logic update;      // apply misses, step address
    logic report;      // load output register
  } dp_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic scan_done;
  } dp_stat_t;

  // clamp a capacity register into 1..MAX_ENTRIES
  function automatic logic [FILL_W-1:0] cap_eff(input logic [CAP_W-1:0] r);
    logic [FILL_W-1:0] v;
    if (r == '0) begin
      v = FILL_W'(1);
    end else if (int'(r) > MAX_ENTRIES) begin
      v = FILL_W'(MAX_ENTRIES);
    end else begin
      v = FILL_W'(r);
    end
    return v;
  endfunction

  // clamp active cache count into 1..NUM_CACHES
  function automatic logic [ACT_W-1:0] act_eff(input logic [ACTREG_W-1:0] r);
    logic [ACT_W-1:0] v;
    if (r == '0) begin
      v = ACT_W'(1);
    end else if (int'(r) > NUM_CACHES) begin
      v = ACT_W'(NUM_CACHES);
    end else begin
      v = ACT_W'(r);
    end
    return v;
  endfunction

endpackage

### hdl/fcmc_channels.sv
// Valid/ready channel interfaces for input items and result items.
interface fcmc_in_if;
  import fcmc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [ADDR_W-1:0] address;
  logic signed [ADDR_W-1:0] stride;
  logic [CNT_W-1:0]         count;
  modport source (output valid, op, address, stride, count, input ready);
  modport sink (input valid, op, address, stride, count, output ready);
endinterface

interface fcmc_out_if;
  import fcmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [MISS_W-1:0] misses_0;
  logic [MISS_W-1:0] misses_1;
  logic [MISS_W-1:0] misses_2;
  logic [MISS_W-1:0] misses_3;
  logic              is_report;
  modport source (output valid, misses_0, misses_1, misses_2, misses_3, is_report,
                  input ready);
  modport sink (input valid, misses_0, misses_1, misses_2, misses_3, is_report,
                output ready);
endinterface

### hdl/fcmc_ctrl.sv
// Sequencer of the FIFO cache miss counter: item intake, scan, update, result.
`include "fifo_cache_miss_counter_defines.svh"

module fcmc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  fcmc_pkg::dp_stat_t stat,
  output fcmc_pkg::dp_cmd_t  cmd
);
  import fcmc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.rem_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = ST_UPDATE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_DONE: begin
        // wait for a free output register
        if (!out_valid_r || out_ready) begin
          cmd.report    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  `FCMC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                    "item accepted while previous one still in work")
  `FCMC_ASSERT_NEXT(a_report_shows, cmd.report, out_valid_r,
                    "result loaded but not presented")
  `FCMC_ASSERT(a_no_overwrite, !(cmd.report && out_valid_r && !out_ready),
               "output register overwritten before taken")

endmodule

### hdl/fcmc_dp.sv
// Datapath: configuration, per-cache entry memories, scan compare, counters.
`include "fifo_cache_miss_counter_defines.svh"

module fcmc_dp (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           cfg_we,
  input  logic [fcmc_pkg::CFG_IDX_W-1:0]                 cfg_index,
  input  logic [fcmc_pkg::CFG_DATA_W-1:0]                cfg_wdata,
  input  logic [fcmc_pkg::OP_W-1:0]                      in_op,
  input  logic [fcmc_pkg::ADDR_W-1:0]                    in_address,
  input  logic [fcmc_pkg::ADDR_W-1:0]                    in_stride,
  input  logic [fcmc_pkg::CNT_W-1:0]                     in_count,
  input  fcmc_pkg::dp_cmd_t                              cmd,
  output fcmc_pkg::dp_stat_t                             stat,
  output logic [fcmc_pkg::NUM_OUT-1:0][fcmc_pkg::MISS_W-1:0] out_misses,
  output logic                                           out_is_report
);
  import fcmc_pkg::*;

  logic [OP_W-1:0]     op_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [ADDR_W-1:0]   stride_r;
  logic [CNT_W-1:0]    rem_r;
  logic [ACTREG_W-1:0] act_r;
  logic [CAP_W-1:0]    capreg_r [NUM_CAP_REGS];
  logic [FILL_W-1:0]   k_r, k_nxt;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_idx_r;

  logic [ACT_W-1:0]    act_eff_w;
  logic [FILL_W-1:0]   scan_len_w;
  logic                issue_w;
  logic                clr_w;
  logic [FILL_W-1:0]   fill_w [NUM_CACHES];
  logic [MISS_W-1:0]   miss_w [NUM_CACHES];

  logic [NUM_OUT-1:0][MISS_W-1:0] out_misses_r;
  logic                           out_rep_r;

  assign act_eff_w = act_eff(act_r);
  assign issue_w   = cmd.scan && (k_r < scan_len_w);
  assign clr_w     = cmd.report && (op_r == OP_STAT);

  // scan length: largest fill count
  always_comb begin
    scan_len_w = '0;
    for (int i = 0; i < NUM_CACHES; i++) begin
      if (fill_w[i] > scan_len_w) begin
        scan_len_w = fill_w[i];
      end
    end
  end

  always_comb begin
    k_nxt = k_r;
    if (cmd.scan_start) begin
      k_nxt = '0;
    end else if (issue_w) begin
      k_nxt = k_r + 1'b1;
    end
  end

  assign stat.rem_zero  = (rem_r == '0);
  assign stat.scan_done = (k_r >= scan_len_w) && !rd_vld_r;

  // item and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      k_r      <= '0;
      rd_vld_r <= 1'b0;
      act_r    <= ACTREG_W'(DEFAULT_ACTIVE);
      for (int i = 0; i < NUM_CAP_REGS; i++) begin
        capreg_r[i] <= CAP_W'(DEFAULT_CAP);
      end
    end else begin
      k_r      <= k_nxt;
      rd_vld_r <= issue_w;
      if (cmd.load) begin
        case (in_op)
          OP_ACCESS: rem_r <= CNT_W'(1);
          OP_RANGE:  rem_r <= in_count;
          default:   rem_r <= '0;
        endcase
      end else if (cmd.update) begin
        rem_r <= rem_r - 1'b1;
      end
      if (cfg_we) begin
        if (cfg_index == REG_ACTIVE) begin
          act_r <= cfg_wdata[ACTREG_W-1:0];
        end
        for (int i = 0; i < NUM_CAP_REGS; i++) begin
          if (cfg_index == CFG_IDX_W'(REG_CAP0 + i)) begin
            capreg_r[i] <= cfg_wdata[CAP_W-1:0];
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r <= k_r[IDX_W-1:0];
    if (cmd.load) begin
      op_r     <= in_op;
      addr_r   <= in_address;
      stride_r <= in_stride;
    end else if (cmd.update) begin
      addr_r <= addr_r + stride_r;
    end
    if (cmd.report) begin
      for (int j = 0; j < NUM_OUT; j++) begin
        out_misses_r[j] <= (j < NUM_CACHES && j < int'(act_eff_w)) ? miss_w[j] : '0;
      end
      out_rep_r <= (op_r == OP_STAT);
    end
  end

  assign out_misses    = out_misses_r;
  assign out_is_report = out_rep_r;

  for (genvar c = 0; c < NUM_CACHES; c++) begin : g_cache
    logic [FILL_W-1:0] fill_r, fill_nxt, cap_w, fill_cl;
    logic [IDX_W-1:0]  wp_r, wp_nxt, wp_cur;
    logic [MISS_W-1:0] miss_r, miss_nxt;
    logic              hit_r, hit_nxt, active_w, miss_ev, flush_w;
    logic [ADDR_W-1:0] rd_data_r;
    logic [ADDR_W-1:0] mem [MAX_ENTRIES];

    if (c < NUM_CAP_REGS) begin : g_cfg
      assign cap_w   = cap_eff(capreg_r[c]);
      assign flush_w = cfg_we && (cfg_index == CFG_IDX_W'(REG_CAP0 + c));
    end else begin : g_fixed
      assign cap_w   = cap_eff(CAP_W'(DEFAULT_CAP));
      assign flush_w = 1'b0;
    end

    assign active_w = (c < int'(act_eff_w));
    assign fill_cl  = (fill_r > cap_w) ? cap_w : fill_r;
    assign miss_ev  = cmd.update && active_w && !hit_r;
    assign wp_cur   = (FILL_W'(wp_r) >= cap_w) ? '0 : wp_r;

    always_comb begin
      hit_nxt = hit_r;
      if (cmd.scan_start) begin
        hit_nxt = 1'b0;
      end else if (rd_vld_r && (FILL_W'(rd_idx_r) < fill_cl) && (rd_data_r == addr_r)) begin
        hit_nxt = 1'b1;
      end
    end

    always_comb begin
      wp_nxt   = wp_r;
      fill_nxt = fill_r;
      miss_nxt = miss_r;
      if (miss_ev) begin
        miss_nxt = (miss_r == '1) ? miss_r : miss_r + 1'b1;
        wp_nxt   = ((FILL_W'(wp_cur) + FILL_W'(1)) >= cap_w) ? '0 : wp_cur + 1'b1;
        fill_nxt = (fill_cl < cap_w) ? fill_cl + 1'b1 : fill_cl;
      end
      if (clr_w) begin
        miss_nxt = '0;
      end
      if (flush_w) begin
        wp_nxt   = '0;
        fill_nxt = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fill_r <= '0;
        wp_r   <= '0;
        miss_r <= '0;
        hit_r  <= 1'b0;
      end else begin
        fill_r <= fill_nxt;
        wp_r   <= wp_nxt;
        miss_r <= miss_nxt;
        hit_r  <= hit_nxt;
      end
    end

    // entry memory: one write, one registered read per cycle
    always_ff @(posedge clk) begin
      if (miss_ev) begin
        mem[wp_cur] <= addr_r;
      end
      if (issue_w) begin
        rd_data_r <= mem[k_r[IDX_W-1:0]];
      end
    end

    assign fill_w[c] = fill_r;
    assign miss_w[c] = miss_r;

    `FCMC_ASSERT(a_fill_in_cap, fill_r <= cap_w, "fill count beyond capacity")
    `FCMC_ASSERT(a_wp_in_cap, FILL_W'(wp_r) < cap_w, "write pointer beyond capacity")
  end

endmodule

### hdl/fifo_cache_miss_counter.sv
// Top level of the FIFO cache miss counter: sequencer plus datapath.
//
// Simulates up to four fully associative caches with FIFO replacement side
// by side and counts their misses. Input items: op 0 looks up one address in
// every active cache, op 1 looks up count addresses starting at address and
// stepping by stride (32-bit wrap), op 2 reports the counters and clears them
// all; op 3 changes nothing. Every item gives exactly one result item with
// the saturating miss counter of each active cache (zero for inactive ones)
// and is_report set for op 2. One item is in work at a time; the result sits
// in an output register, so the next item is taken while it waits.
// Each cache keeps its entries in a memory that is read one entry per cycle,
// all caches in lockstep; a lookup reads F entries, F being the largest fill
// count of the caches at that lookup (0..64), and none when every cache is
// empty. A finished result waits while the previous one is still held in
// the output register. Register 0 holds the active cache count, registers
// 1..4 the capacities; writing a capacity empties that cache but keeps its
// counter. Write configuration only while no item is in work. No clearing
// pass is needed after reset.

module fifo_cache_miss_counter (
  input  logic                             clk,
  input  logic                             rst_n,
  fcmc_in_if.sink                          in_ch,
  fcmc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [fcmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcmc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fcmc_pkg::*;

  dp_cmd_t                        cmd;
  dp_stat_t                       stat;
  logic [NUM_OUT-1:0][MISS_W-1:0] misses;
  logic                           is_report;

  fcmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  fcmc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_op         (in_ch.op),
    .in_address    (in_ch.address),
    .in_stride     (in_ch.stride),
    .in_count      (in_ch.count),
    .cmd           (cmd),
    .stat          (stat),
    .out_misses    (misses),
    .out_is_report (is_report)
  );

  // result fields
  assign out_ch.misses_0  = misses[0];
  assign out_ch.misses_1  = misses[1];
  assign out_ch.misses_2  = misses[2];
  assign out_ch.misses_3  = misses[3];
  assign out_ch.is_report = is_report;

endmodule

### verif/fifo_cache_miss_counter_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the FIFO cache miss counter: directed and random items.
module fifo_cache_miss_counter_test;
  import fcmc_pkg::*;

  // op code 3 has no name in the package; the block must treat it as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int TAIL_CYCLES = 100;          // longer than one worst-case lookup
  localparam int MAX_SHOWN   = 10;           // mismatches printed in full
  localparam int POOL_SIZE   = 48;           // reusable addresses per random phase

  // one result item as the scoreboard keeps it
  typedef struct packed {
    logic [NUM_OUT-1:0][MISS_W-1:0] misses;
    logic                           is_report;
  } miss_report_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fcmc_in_if  in_ch ();
  fcmc_out_if out_ch ();

  fifo_cache_miss_counter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copies plus per-cache tag store, FIFO slot
  // pointer, fill level and saturating miss counter.
  // ---------------------------------------------------------------------------
  logic [ACTREG_W-1:0] active_reg;
  logic [CAP_W-1:0]    cap_reg    [NUM_CAP_REGS];
  logic [ADDR_W-1:0]   tag_store  [NUM_CACHES][MAX_ENTRIES];
  logic [IDX_W-1:0]    next_slot  [NUM_CACHES];
  logic [FILL_W-1:0]   fill_level [NUM_CACHES];
  logic [MISS_W-1:0]   miss_total [NUM_CACHES];

  // predicted result items, oldest first
  miss_report_t expected_counts_q [$];

  // stimulus knobs, in percent
  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  // bookkeeping for the summary
  int fail_count  = 0;
  int n_checked   = 0;
  int n_access    = 0;
  int n_range     = 0;
  int n_lookups   = 0;
  int n_stat      = 0;
  int n_unused    = 0;

  // active cache count after clamping into 1..NUM_CACHES
  function automatic int caches_on();
    int n;
    n = active_reg;
    if (n == 0) n = 1;
    if (n > NUM_CACHES) n = NUM_CACHES;
    return n;
  endfunction

  // capacity of cache c after clamping into 1..MAX_ENTRIES
  function automatic int entries_of(int c);
    int n;
    n = (c < NUM_CAP_REGS) ? int'(cap_reg[c]) : DEFAULT_CAP;
    if (n == 0) n = 1;
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    return n;
  endfunction

  // random filler for the count field of items that do not use it
  function automatic logic [CNT_W-1:0] rand_count();
    return CNT_W'($urandom);
  endfunction

  // one lookup in one cache; a miss counts and takes the next FIFO slot, the oldest once full
  function automatic void lookup(int c, logic [ADDR_W-1:0] addr);
    int cap;
    int fill;
    int slot;
    cap  = entries_of(c);
    fill = fill_level[c];
    if (fill > cap) fill = cap;
    for (int k = 0; k < fill; k++) begin
      if (tag_store[c][k] == addr) return;
    end
    if (miss_total[c] != '1) miss_total[c] = miss_total[c] + 1'b1;
    slot = next_slot[c];
    if (slot >= cap) slot = 0;
    tag_store[c][slot] = addr;
    slot++;
    if (slot >= cap) slot = 0;
    next_slot[c] = IDX_W'(slot);
    if (fill < cap) fill++;
    fill_level[c] = FILL_W'(fill);
  endfunction

  function automatic void lookup_all(logic [ADDR_W-1:0] addr);
    int n;
    n = caches_on();
    for (int c = 0; c < n; c++) lookup(c, addr);
  endfunction

  // applies one input item to the shadow and returns the result it causes
  function automatic miss_report_t predict_miss_counts(logic [OP_W-1:0]   op,
                                                       logic [ADDR_W-1:0] addr,
                                                       logic [ADDR_W-1:0] stride,
                                                       logic [CNT_W-1:0]  count);
    miss_report_t r;
    logic [ADDR_W-1:0] a;
    int n;
    a = addr;
    case (op)
      OP_ACCESS: begin
        lookup_all(a);
      end
      OP_RANGE: begin
        for (int i = 0; i < int'(count); i++) begin
          lookup_all(a);
          a = a + stride;     // 32-bit wrap
        end
      end
      default: begin
      end
    endcase
    n = caches_on();
    r.is_report = (op == OP_STAT);
    for (int j = 0; j < NUM_OUT; j++) begin
      r.misses[j] = (j < n) ? miss_total[j] : '0;
    end
    // stat clears every counter, inactive caches included
    if (op == OP_STAT) begin
      for (int c = 0; c < NUM_CACHES; c++) miss_total[c] = '0;
    end
    return r;
  endfunction

  function automatic void reset_shadow();
    active_reg = ACTREG_W'(DEFAULT_ACTIVE);
    for (int c = 0; c < NUM_CAP_REGS; c++) cap_reg[c] = CAP_W'(DEFAULT_CAP);
    for (int c = 0; c < NUM_CACHES; c++) begin
      next_slot[c]  = '0;
      fill_level[c] = '0;
      miss_total[c] = '0;
      for (int k = 0; k < MAX_ENTRIES; k++) tag_store[c][k] = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The timeout is several times the slowest legal run (big range plus
  // random ranges at full fill under heavy stalls)
  initial begin
    #100_000_000;
    $display("run timed out with %0d result items outstanding", expected_counts_q.size());
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and in-order checking of every item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    miss_report_t want;
    logic bad;
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      n_checked++;
      if (expected_counts_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
          $display("%0t: result item with none expected: %h %h %h %h report %b", $time,
                   out_ch.misses_0, out_ch.misses_1, out_ch.misses_2, out_ch.misses_3,
                   out_ch.is_report);
        end
      end else begin
        want = expected_counts_q.pop_front();
        bad  = (out_ch.misses_0 !== want.misses[0]) || (out_ch.misses_1 !== want.misses[1]) ||
               (out_ch.misses_2 !== want.misses[2]) || (out_ch.misses_3 !== want.misses[3]) ||
               (out_ch.is_report !== want.is_report);
        if (bad) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN) begin
            $display("%0t: mismatch, expected %h %h %h %h report %b", $time,
                     want.misses[0], want.misses[1], want.misses[2], want.misses[3],
                     want.is_report);
            $display("%0t:           got      %h %h %h %h report %b", $time,
                     out_ch.misses_0, out_ch.misses_1, out_ch.misses_2, out_ch.misses_3,
                     out_ch.is_report);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Register write; it waits again after dropping cfg_we so back-to-back writes never put
  // two assignments on cfg_we in the same step. Flush of a capacity write is
  // mirrored in the shadow.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    int c;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ACTIVE) begin
      active_reg = val[ACTREG_W-1:0];
    end else if (int'(idx) >= REG_CAP0 && int'(idx) < REG_CAP0 + NUM_CAP_REGS) begin
      c = int'(idx) - REG_CAP0;
      cap_reg[c] = val[CAP_W-1:0];
      if (c < NUM_CACHES) begin
        next_slot[c]  = '0;
        fill_level[c] = '0;
      end
    end
    @(posedge clk);
  endtask

  task automatic write_all(logic [ACTREG_W-1:0] act, logic [CAP_W-1:0] c0,
                           logic [CAP_W-1:0] c1, logic [CAP_W-1:0] c2, logic [CAP_W-1:0] c3);
    write_reg(REG_ACTIVE, CFG_DATA_W'(act));
    write_reg(CFG_IDX_W'(REG_CAP0 + 0), c0);
    write_reg(CFG_IDX_W'(REG_CAP0 + 1), c1);
    write_reg(CFG_IDX_W'(REG_CAP0 + 2), c2);
    write_reg(CFG_IDX_W'(REG_CAP0 + 3), c3);
  endtask

  // Sends one item and returns at the edge where it was taken, valid still
  // high: the next call either keeps it up or drops it, never both in one step.
  task automatic send_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                           logic [ADDR_W-1:0] stride, logic [CNT_W-1:0] count);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.address <= addr;
    in_ch.stride  <= stride;
    in_ch.count   <= count;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_counts_q.insert(expected_counts_q.size(),
                             predict_miss_counts(op, addr, stride, count));
    case (op)
      OP_ACCESS: n_access++;
      OP_RANGE: begin
        n_range++;
        n_lookups += count;
      end
      OP_STAT: n_stat++;
      default: n_unused++;
    endcase
  endtask

  // drop valid and wait for every outstanding result; the block is idle after
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_counts_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values (4 caches of 16), address extremes, hits, an unknown op,
  // empty range, zero and negative strides, wrap across zero, stat twice.
  task automatic test_reset_defaults();
    send_item(OP_ACCESS, 32'h0000_0000, $urandom, rand_count());
    send_item(OP_ACCESS, 32'h7FFF_FFFF, $urandom, rand_count());
    send_item(OP_ACCESS, 32'h8000_0000, $urandom, rand_count());
    send_item(OP_ACCESS, 32'hFFFF_FFFF, $urandom, rand_count());
    send_item(OP_ACCESS, 32'h0000_0000, $urandom, rand_count());  // hit
    send_item(OP_UNUSED, 32'h0000_0055, $urandom, rand_count());  // no effect
    send_item(OP_RANGE,  32'hAAAA_AAAA, 32'h0000_0001, 16'd0);   // no lookup
    send_item(OP_RANGE,  32'hAAAA_AAAA, 32'h0000_0000, 16'd5);   // one miss, four hits
    send_item(OP_RANGE,  32'h0000_0001, 32'hFFFF_FFFF, 16'd3);   // 1, 0, -1
    send_item(OP_RANGE,  32'h5555_5555, 32'h8000_0000, 16'd4);   // alternates two
    send_item(OP_RANGE,  32'h0000_0010, 32'h7FFF_FFFF, 16'd3);
    send_item(OP_STAT,   $urandom, $urandom, rand_count());
    send_item(OP_STAT,   $urandom, $urandom, rand_count());       // all zero now
    send_item(OP_ACCESS, 32'h7FFF_FFFF, $urandom, rand_count());  // still cached
    wait_drained();
  endtask

  // Clamped register values, FIFO eviction order, flush on capacity write.
  task automatic test_config_extremes();
    write_reg(REG_ACTIVE, '0);                          // counts as one cache
    write_reg(CFG_IDX_W'(REG_CAP0), '0);                // counts as one entry
    send_item(OP_ACCESS, 32'h1234_5678, $urandom, rand_count());
    send_item(OP_ACCESS, 32'h1234_5678, $urandom, rand_count());
    send_item(OP_ACCESS, 32'h0000_DEAD, $urandom, rand_count());  // evicts the only entry
    wait_drained();
    write_all(3'd7, 7'd127, 7'd64, 7'd1, 7'd65);       // above-range values clamp
    // 70 distinct addresses overfill the 64-entry caches
    send_item(OP_RANGE, 32'h0000_0100, 32'h0000_0004, 16'd70);
    // the first six were pushed out, refetching them evicts the next oldest
    send_item(OP_RANGE, 32'h0000_0100, 32'h0000_0004, 16'd6);
    wait_drained();
    write_reg(CFG_IDX_W'(REG_CAP0 + 1), 7'd64);         // flush cache one, keep its count
    send_item(OP_ACCESS, 32'h0000_0214, $urandom, rand_count());
    send_item(OP_STAT, $urandom, $urandom, rand_count());
    wait_drained();
  endtask

  // Longest range, every count bit set; one-entry caches keep it short.
  task automatic test_long_range();
    write_all(3'd4, 7'd1, 7'd1, 7'd1, 7'd1);
    send_item(OP_RANGE, 32'h0F0F_0F0F, 32'h8000_0001, 16'hFFFF);
    send_item(OP_STAT, $urandom, $urandom, rand_count());
    wait_drained();
  endtask

  // Random items drawn mostly from a small address pool so that hits,
  // evictions and refills all happen; the rest are fresh addresses.
  task automatic random_items(int n);
    logic [ADDR_W-1:0] pool [POOL_SIZE];
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] stride;
    logic [CNT_W-1:0]  count;
    int pool_n;
    int pick;
    pool_n = $urandom_range(4, POOL_SIZE);
    foreach (pool[i]) pool[i] = $urandom;
    repeat (n) begin
      pick = $urandom_range(99);
      addr = ($urandom_range(99) < 85) ? pool[$urandom_range(pool_n - 1)] : $urandom;
      if (pick < 45) begin
        send_item(OP_ACCESS, addr, $urandom, rand_count());
      end else if (pick < 80) begin
        case ($urandom_range(4))
          0, 1, 2: begin
            stride = $urandom_range(8);
            stride = stride - 4;                          // -4..4
          end
          3: stride = pool[$urandom_range(pool_n - 1)] - addr;
          default: stride = $urandom;
        endcase
        pick = $urandom_range(99);
        if (pick < 70) count = CNT_W'($urandom_range(1, 8));
        else if (pick < 90) count = CNT_W'($urandom_range(24));
        else count = '0;
        send_item(OP_RANGE, addr, stride, count);
      end else if (pick < 92) begin
        send_item(OP_STAT, addr, $urandom, rand_count());
      end else begin
        send_item(OP_UNUSED, addr, $urandom, rand_count());
      end
    end
  endtask

  // Four phases, each with its own flow-control pattern and cache setup.
  task automatic test_random_traffic();
    wait_drained();
    in_idle_pct = 0;   out_stall_pct = 0;
    write_all(3'd4, 7'd1, 7'd64, 7'd5, 7'd100);
    random_items(225);

    wait_drained();
    in_idle_pct = 81;  out_stall_pct = 0;
    write_all(3'd2, 7'd3, 7'd8, 7'd0, 7'd33);
    random_items(225);

    wait_drained();
    in_idle_pct = 0;   out_stall_pct = 81;
    write_all(3'd5, 7'd64, 7'd2, 7'd16, 7'd127);
    random_items(225);

    wait_drained();
    in_idle_pct = 24;  out_stall_pct = 24;
    write_all(3'd3, 7'd12, 7'd1, 7'd40, 7'd7);
    random_items(225);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.op      <= OP_ACCESS;
    in_ch.address <= '0;
    in_ch.stride  <= '0;
    in_ch.count   <= '0;
    reset_shadow();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_long_range();
    test_random_traffic();

    // let any stray result surface before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_counts_q.size() != 0) begin
      $display("%0d expected result items never arrived", expected_counts_q.size());
      fail_count += expected_counts_q.size();
    end

    $display("covered %0d access, %0d range (%0d lookups), %0d stat, %0d no-op items",
             n_access, n_range, n_lookups, n_stat, n_unused);
    $display("checked %0d result items under four flow-control phases, %0d failures",
             n_checked, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
